// ----- rtl/tovn_pkg.sv -----
`timescale 1ns / 1ps

package tovn_pkg;

   // Default sizes of the coordinate ports and of the internal fraction
   localparam int DEF_COORD_BITS = 16;
   localparam int DEF_FRAC_BITS  = 16;

   // Fixed field widths
   localparam int SCALE_W = 17;
   localparam int SEED_W  = 32;
   localparam int OUT_W   = 16;

   // Corner hash constants
   localparam logic [31:0] HASH_MULT_X     = 32'd374761393;
   localparam logic [31:0] HASH_MULT_Y     = 32'd668265263;
   localparam logic [31:0] SEED_MULT       = 32'd362437;
   localparam logic [31:0] HASH_MIX        = 32'd1274126177;
   localparam logic [23:0] CORNER_DIV      = 24'hffffff;
   localparam logic [31:0] COARSE_SEED_OFS = 32'd17;

   // Register reset values
   localparam logic [SEED_W-1:0]  SEED_RST        = '0;
   localparam logic [SCALE_W-1:0] INV_FINE_RST    = 17'd8192;
   localparam logic [SCALE_W-1:0] INV_COARSE_RST  = 17'd3413;
   localparam logic               CONTRAST_RST    = 1'b0;

   // Register stages through one octave
   localparam int OCT_LAT = 10;

   // Register map
   typedef enum logic [1:0] {
      REG_SEED       = 2'd0,
      REG_INV_FINE   = 2'd1,
      REG_INV_COARSE = 2'd2,
      REG_CONTRAST   = 2'd3
   } reg_index_type;

endpackage

// ----- rtl/tovn_octave.sv -----
`timescale 1ns / 1ps

module tovn_octave
   import tovn_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
   input  logic                         clock,
   input  logic signed [COORD_BITS-1:0] x_coord,
   input  logic signed [COORD_BITS-1:0] y_coord,
   input  logic        [SCALE_W-1:0]    inv_scale,
   input  logic        [31:0]           seed_term,
   output logic        [FRAC_BITS:0]    octave_value
);

   localparam int F   = FRAC_BITS;
   localparam int PW  = COORD_BITS + SCALE_W + 1;   // scaled position
   localparam int CW  = PW - 16;                    // cell index
   localparam int TW  = F + 16;
   localparam int FUP = (F >= 16) ? F - 16 : 0;
   localparam int FDN = (F < 16) ? 16 - F : 0;
   localparam int XW  = F + 25;
   localparam int AW  = 26;

   localparam logic [F:0]     ONE_F     = {1'b1, {F{1'b0}}};
   localparam logic [F+1:0]   THREE_ONE = (F + 2)'(3) << F;
   localparam logic [2*F+2:0] HALF_W    = (2 * F + 3)'(1) << (F - 1);

   // stage 1: scale
   logic signed [SCALE_W:0] inv_s;
   logic signed [PW-1:0]    px_in, py_in, px_ff, py_ff;

   assign inv_s = $signed({1'b0, inv_scale});
   assign px_in = x_coord * inv_s;
   assign py_in = y_coord * inv_s;

   always_ff @(posedge clock) begin
      px_ff <= px_in;
      py_ff <= py_in;
   end

   // stage 2: cell split, lattice products, fraction square
   logic signed [CW-1:0] cell_x, cell_y;
   logic [31:0]          hx0_in, hy0_in, hx0_ff, hy0_ff;
   logic [F-1:0]         t_in [2];
   logic [F-1:0]         t_ff [2];
   logic [2*F-1:0]       tt_in [2];
   logic [2*F-1:0]       tt_ff [2];

   assign cell_x = px_ff[PW-1:16];
   assign cell_y = py_ff[PW-1:16];
   assign hx0_in = 32'(cell_x) * HASH_MULT_X;
   assign hy0_in = 32'(cell_y) * HASH_MULT_Y;
   assign t_in[0] = F'((TW'(px_ff[15:0]) << FUP) >> FDN);
   assign t_in[1] = F'((TW'(py_ff[15:0]) << FUP) >> FDN);

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         tt_in[k] = t_in[k] * t_in[k];
      end
   end

   always_ff @(posedge clock) begin
      hx0_ff <= hx0_in;
      hy0_ff <= hy0_in;
      t_ff   <= t_in;
      tt_ff  <= tt_in;
   end

   // stage 3: corner hash sums with first xorshift; fade polynomial
   logic [31:0]      hx_opt [2];
   logic [31:0]      hy_opt [2];
   logic [31:0]      hsum [4];
   logic [31:0]      hp_in [4];
   logic [31:0]      hp_ff [4];
   logic [2*F:0]     t2sum [2];
   logic [F:0]       t2 [2];
   logic [F+1:0]     wt [2];
   logic [2*F+2:0]   fp_in [2];
   logic [2*F+2:0]   fp_ff [2];

   assign hx_opt[0] = hx0_ff;
   assign hx_opt[1] = hx0_ff + HASH_MULT_X;
   assign hy_opt[0] = hy0_ff;
   assign hy_opt[1] = hy0_ff + HASH_MULT_Y;

   // corner order: (cx,cy), (cx+1,cy), (cx,cy+1), (cx+1,cy+1)
   assign hsum[0] = hx_opt[0] + hy_opt[0] + seed_term;
   assign hsum[1] = hx_opt[1] + hy_opt[0] + seed_term;
   assign hsum[2] = hx_opt[0] + hy_opt[1] + seed_term;
   assign hsum[3] = hx_opt[1] + hy_opt[1] + seed_term;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         hp_in[i] = hsum[i] ^ (hsum[i] >> 13);
      end
      for (int k = 0; k < 2; k++) begin
         t2sum[k] = {1'b0, tt_ff[k]} + HALF_W[2*F:0];
         t2[k]    = t2sum[k][2*F:F];
         wt[k]    = THREE_ONE - (F + 2)'({t_ff[k], 1'b0});
         fp_in[k] = t2[k] * wt[k];
      end
   end

   always_ff @(posedge clock) begin
      hp_ff <= hp_in;
      fp_ff <= fp_in;
   end

   // stage 4: hash mix multiply; fade weight rounding
   logic [31:0]    hm_in [4];
   logic [31:0]    hm_ff [4];
   logic [2*F+2:0] usum [2];
   logic [F:0]     uv_in [2];
   logic [F:0]     uv4_ff [2];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         hm_in[i] = hp_ff[i] * HASH_MIX;
      end
      for (int k = 0; k < 2; k++) begin
         usum[k]  = fp_ff[k] + HALF_W;
         uv_in[k] = usum[k][2*F:F];
      end
   end

   always_ff @(posedge clock) begin
      hm_ff  <= hm_in;
      uv4_ff <= uv_in;
   end

   // stage 5: final xorshift, first fold of the divide by 2^24-1
   logic [31:0]   hf [4];
   logic [XW-1:0] xw [4];
   logic [F:0]    a_in [4];
   logic [F:0]    a_ff [4];
   logic [AW-1:0] s1_in [4];
   logic [AW-1:0] s1_ff [4];
   logic [F:0]    uv5_ff [2];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         hf[i]    = hm_ff[i] ^ (hm_ff[i] >> 16);
         xw[i]    = {hf[i][23:0], (F + 1)'(0)};
         a_in[i]  = xw[i][XW-1:24];
         s1_in[i] = AW'(a_in[i]) + AW'(xw[i][23:0]);
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      s1_ff  <= s1_in;
      uv5_ff <= uv4_ff;
   end

   // stage 6: second fold, end correction and halving to the corner value
   logic [1:0]   a2 [4];
   logic [24:0]  s2 [4];
   logic         cf [4];
   logic [F+2:0] qs [4];
   logic [F:0]   corner_in [4];
   logic [F:0]   corner_ff [4];
   logic [F:0]   uv6_ff [2];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         a2[i]        = s1_ff[i][AW-1:24];
         s2[i]        = 25'(s1_ff[i][23:0]) + 25'(a2[i]);
         cf[i]        = s2[i] >= 25'(CORNER_DIV);
         qs[i]        = (F + 3)'(a_ff[i]) + (F + 3)'(a2[i]) + (F + 3)'(cf[i]) + (F + 3)'(1);
         corner_in[i] = qs[i][F+1:1];
      end
   end

   always_ff @(posedge clock) begin
      corner_ff <= corner_in;
      uv6_ff    <= uv5_ff;
   end

   // stage 7: weighted corners along x
   logic [F:0]     omu;
   logic [2*F+1:0] lp_in [4];
   logic [2*F+1:0] lp_ff [4];
   logic [F:0]     v7_ff;

   assign omu      = ONE_F - uv6_ff[0];
   assign lp_in[0] = corner_ff[0] * omu;
   assign lp_in[1] = corner_ff[1] * uv6_ff[0];
   assign lp_in[2] = corner_ff[2] * omu;
   assign lp_in[3] = corner_ff[3] * uv6_ff[0];

   always_ff @(posedge clock) begin
      lp_ff <= lp_in;
      v7_ff <= uv6_ff[1];
   end

   // stage 8: row values
   logic [2*F+2:0] rsum [2];
   logic [F:0]     row_in [2];
   logic [F:0]     row_ff [2];
   logic [F:0]     v8_ff;

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         rsum[j]   = (2 * F + 3)'(lp_ff[2*j]) + (2 * F + 3)'(lp_ff[2*j+1]) + HALF_W;
         row_in[j] = rsum[j][2*F:F];
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      v8_ff  <= v7_ff;
   end

   // stage 9: weighted rows along y
   logic [2*F+1:0] vp_in [2];
   logic [2*F+1:0] vp_ff [2];

   assign vp_in[0] = row_ff[0] * (ONE_F - v8_ff);
   assign vp_in[1] = row_ff[1] * v8_ff;

   always_ff @(posedge clock) begin
      vp_ff <= vp_in;
   end

   // stage 10: octave value
   logic [2*F+2:0] nsum;
   logic [F:0]     n_ff;

   assign nsum = (2 * F + 3)'(vp_ff[0]) + (2 * F + 3)'(vp_ff[1]) + HALF_W;

   always_ff @(posedge clock) begin
      n_ff <= nsum[2*F:F];
   end

   assign octave_value = n_ff;

endmodule

// ----- rtl/tovn_post.sv -----
`timescale 1ns / 1ps

module tovn_post
   import tovn_pkg::*;
#(
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [FRAC_BITS:0] fine_value,
   input  logic [FRAC_BITS:0] coarse_value,
   input  logic               contrast_enable,
   output logic               out_valid,
   output logic [OUT_W-1:0]   noise_value
);

   localparam int F       = FRAC_BITS;
   localparam int MW      = F + 1;
   localparam int SW      = F + 10;
   localparam int YW      = F + 6;
   localparam int RW      = F + 2;
   localparam int EW      = F + 18;
   localparam int UP_SH   = (F > 16) ? F - 16 : 0;
   localparam int DN_SH   = (F < 16) ? 16 - F : 0;
   localparam int POST_LAT = 5;

   localparam logic [MW-1:0] ONE_F    = MW'(1) << F;
   localparam logic [SW-1:0] K85      = SW'(85) << F;
   localparam logic [RW-1:0] RECIP_25 = RW'((64'd1 << YW) / 64'd25);
   localparam logic [EW-1:0] HALF_UP  = (EW'(1) << UP_SH) >> 1;

   // valid bits through the five stages
   logic [POST_LAT-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[POST_LAT-2:0], in_valid};
      end
   end

   // mix 3/4 fine + 1/4 coarse
   logic [F+2:0]  msum;
   logic [MW-1:0] m_ff;

   assign msum = (F + 3)'({fine_value, 1'b0}) + (F + 3)'(fine_value)
               + (F + 3)'(coarse_value) + (F + 3)'(2);

   always_ff @(posedge clock) begin
      m_ff <= msum[F+2:2];
   end

   // contrast: 370*t - 85*ONE, rounding offset, drop three bits of the /200
   logic [SW-1:0] p370;
   logic [SW-1:0] ysum;
   logic          zero_in, zero12_ff;
   logic [YW-1:0] y12_ff;
   logic [MW-1:0] m12_ff;

   assign p370    = SW'(m_ff) * SW'(370);
   assign zero_in = p370 <= K85;
   assign ysum    = p370 - K85 + SW'(100);

   always_ff @(posedge clock) begin
      y12_ff    <= ysum[YW+2:3];
      zero12_ff <= zero_in;
      m12_ff    <= m_ff;
   end

   // divide by 25 through the reciprocal
   logic [YW+RW-1:0] yr;
   logic [RW-1:0]    q0_ff;
   logic [YW-1:0]    y13_ff;
   logic             zero13_ff;
   logic [MW-1:0]    m13_ff;

   assign yr = y12_ff * RECIP_25;

   always_ff @(posedge clock) begin
      q0_ff     <= yr[YW+RW-1:YW];
      y13_ff    <= y12_ff;
      zero13_ff <= zero12_ff;
      m13_ff    <= m12_ff;
   end

   // reciprocal correction, clamp to one, bypass when contrast is off
   logic [YW-1:0] rem;
   logic [RW-1:0] qc;
   logic [MW-1:0] qv;
   logic [MW-1:0] val_in, val_ff;

   assign rem = y13_ff - YW'(q0_ff) * YW'(25);
   assign qc  = q0_ff + RW'(rem >= YW'(25));
   assign qv  = (qc > RW'(ONE_F)) ? ONE_F : qc[MW-1:0];

   always_comb begin
      if (!contrast_enable) begin
         val_in = m13_ff;
      end else if (zero13_ff) begin
         val_in = '0;
      end else begin
         val_in = qv;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   // resize to 16 fraction bits and saturate
   logic [EW-1:0]    ow;
   logic [OUT_W-1:0] out_in, out_ff;

   assign ow     = ((EW'(val_ff) << DN_SH) + HALF_UP) >> UP_SH;
   assign out_in = (ow > EW'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : ow[OUT_W-1:0];

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign out_valid   = vld_ff[POST_LAT-1];
   assign noise_value = out_ff;

endmodule

// ----- rtl/two_octave_value_noise_core.sv -----
`timescale 1ns / 1ps
// Two-octave 2-D value noise.
// Request: drive req_x_coord / req_y_coord and pulse start; a beat is taken
// at every rising edge with start high and busy low. busy is always low, so
// a new coordinate pair may be issued on every cycle.
// Result: rsp_noise_value is shown for one cycle with rsp_valid high, in
// request order. There is no back-pressure on the result side; results must
// be captured as they come. Throughput is one beat per clock. A request
// passes through the input register, loaded at the edge that takes the
// request, then the ten register stages of each octave (scale, hash
// multiplies, divide by 2^24-1, two lerp passes) and five stages of mix,
// contrast and output rounding.
// Configuration: csr_we writes csr_wdata to register csr_index (0 seed,
// 1 fine reciprocal, 2 coarse reciprocal, 3 contrast enable) on the same
// edge. Write only while no beat is in flight.
// Reset: synchronous, clears the pipeline valid bits and loads the register
// defaults (seed 0, fine 8192, coarse 3413, contrast off).
module two_octave_value_noise_core
   import tovn_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_x_coord,
   input  logic signed [COORD_BITS-1:0] req_y_coord,
   output logic                         rsp_valid,
   output logic        [OUT_W-1:0]      rsp_noise_value,
   input  logic                         csr_we,
   input  logic        [1:0]            csr_index,
   input  logic        [SEED_W-1:0]     csr_wdata
);

   // configuration registers
   logic [SEED_W-1:0]  seed_ff;
   logic [SCALE_W-1:0] inv_fine_ff;
   logic [SCALE_W-1:0] inv_coarse_ff;
   logic               contrast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff       <= SEED_RST;
         inv_fine_ff   <= INV_FINE_RST;
         inv_coarse_ff <= INV_COARSE_RST;
         contrast_ff   <= CONTRAST_RST;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_SEED:       seed_ff       <= csr_wdata;
            REG_INV_FINE:   inv_fine_ff   <= csr_wdata[SCALE_W-1:0];
            REG_INV_COARSE: inv_coarse_ff <= csr_wdata[SCALE_W-1:0];
            REG_CONTRAST:   contrast_ff   <= csr_wdata[0];
         endcase
      end
   end

   // seed contribution to the hash, one per octave
   logic [31:0] seedk_fine_in, seedk_coarse_in, seedk_fine_ff, seedk_coarse_ff;

   assign seedk_fine_in   = seed_ff * SEED_MULT;
   assign seedk_coarse_in = (seed_ff + COARSE_SEED_OFS) * SEED_MULT;

   always_ff @(posedge clock) begin
      seedk_fine_ff   <= seedk_fine_in;
      seedk_coarse_ff <= seedk_coarse_in;
   end

   // the pipeline never holds off a request
   logic req_fire;

   assign busy     = 1'b0;
   assign req_fire = start & ~busy;

   // input register
   logic                         req_vld_ff;
   logic signed [COORD_BITS-1:0] x_ff, y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= req_x_coord;
      y_ff <= req_y_coord;
   end

   // valid bits alongside the octave stages
   logic [OCT_LAT-1:0] oct_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_vld_ff <= '0;
      end else begin
         oct_vld_ff <= {oct_vld_ff[OCT_LAT-2:0], req_vld_ff};
      end
   end

   // the two octaves
   logic [FRAC_BITS:0] fine_value, coarse_value;

   tovn_octave #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_fine (
      .clock        (clock),
      .x_coord      (x_ff),
      .y_coord      (y_ff),
      .inv_scale    (inv_fine_ff),
      .seed_term    (seedk_fine_ff),
      .octave_value (fine_value)
   );

   tovn_octave #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_coarse (
      .clock        (clock),
      .x_coord      (x_ff),
      .y_coord      (y_ff),
      .inv_scale    (inv_coarse_ff),
      .seed_term    (seedk_coarse_ff),
      .octave_value (coarse_value)
   );

   // mix, contrast and output stage
   tovn_post #(
      .FRAC_BITS (FRAC_BITS)
   ) u_post (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (oct_vld_ff[OCT_LAT-1]),
      .fine_value      (fine_value),
      .coarse_value    (coarse_value),
      .contrast_enable (contrast_ff),
      .out_valid       (rsp_valid),
      .noise_value     (rsp_noise_value)
   );

endmodule

// ----- verif/two_octave_value_noise_core_test.sv -----
`timescale 1ns / 1ps

module two_octave_value_noise_core_test;
   import tovn_pkg::*;

   localparam int CW      = DEF_COORD_BITS;
   localparam int LATENCY = 16;
   localparam int RANDOM_BEATS = 400;

   // Arithmetic constants of the noise, kept apart from the package copies
   localparam logic [63:0] UNIT       = 64'd65536;
   localparam logic [63:0] HALF_UNIT  = 64'd32768;
   localparam logic [63:0] H24_MAX    = 64'hffffff;
   localparam logic [31:0] MUL_X      = 32'd374761393;
   localparam logic [31:0] MUL_Y      = 32'd668265263;
   localparam logic [31:0] MUL_SEED   = 32'd362437;
   localparam logic [31:0] MUL_MIX    = 32'd1274126177;
   localparam logic [31:0] COARSE_OFS = 32'd17;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      coord_type        x;
      coord_type        y;
      logic [OUT_W-1:0] value;
   } noise_beat_type;

   typedef enum logic {
      ROW_POINT,
      ROW_REGS
   } row_kind_type;

   // One directed row: a coordinate beat, or a full set of register writes
   typedef struct packed {
      row_kind_type kind;
      coord_type    x;
      coord_type    y;
      logic [31:0]  seed;
      logic [31:0]  fine;
      logic [31:0]  coarse;
      logic [31:0]  ctl;
   } stim_row_type;

   localparam int NROWS = 26;
   localparam stim_row_type DIRECTED_ROWS [NROWS] = '{
      // reset settings: corners of the coordinate range and points near the origin
      '{ROW_POINT, 16'sh0000, 16'sh0000, 32'h0, 32'h0, 32'h0, 32'h0},
      '{ROW_POINT, 16'sh7fff, 16'sh7fff, 32'h0, 32'h0, 32'h0, 32'h0},
      '{ROW_POINT, 16'sh8000, 16'sh8000, 32'h0, 32'h0, 32'h0, 32'h0},
      '{ROW_POINT, 16'shffff, 16'sh0001, 32'h0, 32'h0, 32'h0, 32'h0},
      '{ROW_POINT, 16'sh7fff, 16'sh8000, 32'h0, 32'h0, 32'h0, 32'h0},
      '{ROW_POINT, 16'sh0001, 16'shffff, 32'h0, 32'h0, 32'h0, 32'h0},
      // zero scale: every point lands on corner (0,0)
      '{ROW_REGS, 16'sh0, 16'sh0, 32'h0000_0000, 32'h0, 32'h0, 32'h0},
      '{ROW_POINT, 16'sh3039, 16'shefdf, 32'h0, 32'h0, 32'h0, 32'h0},
      '{ROW_POINT, 16'sh8000, 16'sh7fff, 32'h0, 32'h0, 32'h0, 32'h0},
      // unit scale: fraction always zero
      '{ROW_REGS, 16'sh0, 16'sh0, 32'h5a5a_5a5a, 32'h1_0000, 32'h1_0000, 32'h0},
      '{ROW_POINT, 16'sh8000, 16'sh8000, 32'h0, 32'h0, 32'h0, 32'h0},
      '{ROW_POINT, 16'sh7fff, 16'sh7fff, 32'h0, 32'h0, 32'h0, 32'h0},
      // scale above one, junk in the upper write bits, contrast bit clear
      '{ROW_REGS, 16'sh0, 16'sh0, 32'ha5c3_0f96, 32'hffff_ffff, 32'h0001_ffff,
        32'hffff_fffe},
      '{ROW_POINT, 16'sh8000, 16'sh7fff, 32'h0, 32'h0, 32'h0, 32'h0},
      '{ROW_POINT, 16'shffff, 16'shffff, 32'h0, 32'h0, 32'h0, 32'h0},
      // coarse seed wraps past 2^32, tiny fine scale, coarse scale just above one, contrast on
      '{ROW_REGS, 16'sh0, 16'sh0, 32'hffff_ffff, 32'h1, 32'h1_0001, 32'hffff_ffff},
      '{ROW_POINT, 16'sh7fff, 16'sh8000, 32'h0, 32'h0, 32'h0, 32'h0},
      '{ROW_POINT, 16'sh0001, 16'sh0001, 32'h0, 32'h0, 32'h0, 32'h0},
      // default scales with contrast stretch
      '{ROW_REGS, 16'sh0, 16'sh0, 32'h0, 32'd8192, 32'd3413, 32'h1},
      '{ROW_POINT, 16'sh0000, 16'sh0000, 32'h0, 32'h0, 32'h0, 32'h0},
      '{ROW_POINT, 16'sh7fff, 16'sh7fff, 32'h0, 32'h0, 32'h0, 32'h0},
      '{ROW_POINT, 16'sh8000, 16'sh8000, 32'h0, 32'h0, 32'h0, 32'h0},
      '{ROW_POINT, 16'sh1234, 16'shedcb, 32'h0, 32'h0, 32'h0, 32'h0},
      '{ROW_POINT, 16'sh0100, 16'shff00, 32'h0, 32'h0, 32'h0, 32'h0},
      '{ROW_POINT, 16'sh5555, 16'shaaaa, 32'h0, 32'h0, 32'h0, 32'h0},
      '{ROW_POINT, 16'shaaaa, 16'sh5555, 32'h0, 32'h0, 32'h0, 32'h0}
   };

   logic               clock;
   logic               reset       = 1'b1;
   logic               start       = 1'b0;
   logic               busy;
   coord_type          req_x_coord = '0;
   coord_type          req_y_coord = '0;
   logic               rsp_valid;
   logic [OUT_W-1:0]   rsp_noise_value;
   logic               csr_we      = 1'b0;
   logic [1:0]         csr_index   = '0;
   logic [SEED_W-1:0]  csr_wdata   = '0;

   // Shadow copy of the block's registers
   logic [31:0]        seed_q;
   logic [16:0]        fine_q;
   logic [16:0]        coarse_q;
   logic               contrast_q;

   noise_beat_type     pending_noise [$];
   int                 fault_count = 0;

   two_octave_value_noise_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .rsp_valid       (rsp_valid),
      .rsp_noise_value (rsp_noise_value),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("two_octave_value_noise_core verification failed");
      $finish;
   end

   // ---------------------------------------------------------------- noise model

   // Hashed corner level in Q1.16, 0..1
   function automatic logic [63:0] corner_level(logic [31:0] cx, logic [31:0] cy,
                                                logic [31:0] seed);
      logic [31:0] h;
      h = cx * MUL_X + cy * MUL_Y + seed * MUL_SEED;
      h = (h ^ (h >> 13)) * MUL_MIX;
      h = h ^ (h >> 16);
      return ({40'd0, h[23:0]} * UNIT * 2 + H24_MAX) / (2 * H24_MAX);
   endfunction

   // Smoothstep weight of a Q0.16 fraction
   function automatic logic [63:0] fade(logic [63:0] t);
      logic [63:0] t2;
      t2 = (t * t + HALF_UNIT) >> 16;
      return (t2 * (3 * UNIT - 2 * t) + HALF_UNIT) >> 16;
   endfunction

   function automatic logic [63:0] blend(logic [63:0] a, logic [63:0] b, logic [63:0] w);
      return (a * (UNIT - w) + b * w + HALF_UNIT) >> 16;
   endfunction

   function automatic logic [63:0] octave_level(coord_type x, coord_type y,
                                                logic [16:0] inv, logic [31:0] seed);
      logic signed [63:0] px;
      logic signed [63:0] py;
      logic signed [63:0] inv_s;
      logic [31:0]        cx;
      logic [31:0]        cy;
      logic [63:0]        wx;
      logic [63:0]        wy;
      px    = x;
      py    = y;
      inv_s = {47'd0, inv};
      px    = px * inv_s;
      py    = py * inv_s;
      // floor of the scaled position, kept to 32 bits for the hash
      cx = px[47:16];
      cy = py[47:16];
      wx = fade({48'd0, px[15:0]});
      wy = fade({48'd0, py[15:0]});
      return blend(blend(corner_level(cx, cy, seed), corner_level(cx + 32'd1, cy, seed), wx),
                   blend(corner_level(cx, cy + 32'd1, seed),
                         corner_level(cx + 32'd1, cy + 32'd1, seed), wx),
                   wy);
   endfunction

   function automatic logic [OUT_W-1:0] predict_noise(coord_type x, coord_type y);
      logic [63:0]        n;
      logic signed [63:0] s;
      n = (3 * octave_level(x, y, fine_q, seed_q)
           + octave_level(x, y, coarse_q, seed_q + COARSE_OFS) + 2) >> 2;
      // contrast: 0.5 + (n - 0.5) * 1.85, clamped to 0..1
      if (contrast_q) begin
         s = $signed(370 * n) - $signed(85 * UNIT);
         if (s <= 0) begin
            n = 0;
         end else begin
            n = (s + 100) / 200;
            if (n > UNIT) n = UNIT;
         end
      end
      return (n > 64'd65535) ? 16'hffff : n[15:0];
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic flag_fault(input string msg);
      if (fault_count < 10) $display("%s", msg);
      fault_count++;
   endtask

   always @(posedge clock) begin : watch_beats
      noise_beat_type want;
      if (reset) begin
         seed_q     = 32'd0;
         fine_q     = 17'd8192;
         coarse_q   = 17'd3413;
         contrast_q = 1'b0;
      end else begin
         // retire the result first, then log any beat taken at this edge
         if (rsp_valid) begin
            if (pending_noise.size() == 0) begin
               flag_fault($sformatf("unexpected noise beat %h", rsp_noise_value));
            end else begin
               want = pending_noise.pop_front();
               if (rsp_noise_value !== want.value)
                  flag_fault($sformatf("noise at (%0d,%0d): expected %h got %h",
                                       want.x, want.y, want.value, rsp_noise_value));
            end
         end
         if (start && !busy)
            pending_noise.push_back({req_x_coord, req_y_coord,
                                     predict_noise(req_x_coord, req_y_coord)});
         if (csr_we) begin
            case (csr_index)
               REG_SEED:       seed_q     = csr_wdata;
               REG_INV_FINE:   fine_q     = csr_wdata[16:0];
               REG_INV_COARSE: coarse_q   = csr_wdata[16:0];
               REG_CONTRAST:   contrast_q = csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   // Holds start high until the beat is taken; start stays high on return
   task automatic send_point(input coord_type x, input coord_type y);
      start       <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      do @(posedge clock); while (busy);
   endtask

   // Gap with junk on the coordinate ports
   task automatic idle_for(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) begin
            req_x_coord <= coord_type'($urandom);
            req_y_coord <= coord_type'($urandom);
            @(posedge clock);
         end
      end
   endtask

   // Stop sending and wait for every outstanding result
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_noise.size() != 0);
   endtask

   task automatic load_regs(input logic [31:0] seed, input logic [31:0] fine,
                            input logic [31:0] coarse, input logic [31:0] ctl);
      csr_we    <= 1'b1;
      csr_index <= REG_SEED;
      csr_wdata <= seed;
      @(posedge clock);
      csr_index <= REG_INV_FINE;
      csr_wdata <= fine;
      @(posedge clock);
      csr_index <= REG_INV_COARSE;
      csr_wdata <= coarse;
      @(posedge clock);
      csr_index <= REG_CONTRAST;
      csr_wdata <= ctl;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic coord_type pick_coord();
      case ($urandom_range(0, 7))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return '0;
         3:       return '1;
         default: return coord_type'($urandom);
      endcase
   endfunction

   // Scale register value with random junk above bit 16
   function automatic logic [31:0] pick_scale();
      logic [16:0] v;
      case ($urandom_range(0, 7))
         0:       v = 17'd0;
         1:       v = 17'd1;
         2:       v = 17'd65535;
         3:       v = 17'd65536;
         4:       v = 17'h1ffff;
         5:       v = 17'($urandom_range(0, 131071));
         default: v = 17'($urandom_range(1000, 16000));
      endcase
      return (32'($urandom) & 32'hfffe_0000) | {15'd0, v};
   endfunction

   function automatic logic [31:0] pick_seed();
      case ($urandom_range(0, 4))
         0:       return 32'h0;
         1:       return 32'hffff_ffff;
         2:       return 32'hffff_ffef;
         default: return 32'($urandom);
      endcase
   endfunction

   initial begin : drive_stimulus
      int        sent;
      int        phase;
      int        left;
      int        burst;
      bit        raster;
      bit        pressed;
      coord_type x0;
      coord_type y0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < NROWS; i++) begin
         if (DIRECTED_ROWS[i].kind == ROW_REGS) begin
            drain();
            load_regs(DIRECTED_ROWS[i].seed, DIRECTED_ROWS[i].fine,
                      DIRECTED_ROWS[i].coarse, DIRECTED_ROWS[i].ctl);
         end else begin
            send_point(DIRECTED_ROWS[i].x, DIRECTED_ROWS[i].y);
            if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 4));
         end
      end

      // random phases, each under its own register setting
      sent    = 0;
      phase   = 0;
      pressed = 1'b0;
      while (sent < RANDOM_BEATS) begin
         drain();
         load_regs(pick_seed(), pick_scale(), pick_scale(), 32'($urandom));
         left = $urandom_range(20, 60);
         while (left > 0 && sent < RANDOM_BEATS) begin
            burst  = $urandom_range(1, 24);
            if (burst > left) burst = left;
            // raster runs walk neighbouring x coordinates as a texture sweep would
            raster = ($urandom_range(0, 3) == 0);
            x0     = pick_coord();
            y0     = pick_coord();
            for (int k = 0; k < burst; k++) begin
               if (raster) send_point(x0 + coord_type'(k), y0);
               else        send_point(pick_coord(), pick_coord());
            end
            left -= burst;
            sent += burst;
            if (phase == 1 && !pressed) begin
               drain();
               pressed = 1'b1;
            end else if ($urandom_range(0, 2) != 0) begin
               idle_for($urandom_range(1, 10));
            end
         end
         phase++;
      end

      drain();
      repeat (LATENCY + 4) @(posedge clock);
      if (fault_count == 0 && pending_noise.size() == 0) begin
         $display("two_octave_value_noise_core verification clean");
      end else begin
         $display("two_octave_value_noise_core verification failed");
      end
      $finish;
   end

endmodule
